/* sv/bss_pkg.sv */
package bss_pkg;

	// Fixed field widths of the beats
	localparam int DATA_W    = 8;
	localparam int CNT_W     = 7;
	localparam int SUM_W     = 14;

	// Mean divider: dividend is 2*sum + count, divisor is 2*count
	localparam int DIV_W     = SUM_W + 1;
	localparam int DIVISOR_W = CNT_W + 1;
	localparam int DCNT_W    = $clog2(DIV_W);

	localparam logic [DATA_W-1:0] MIN_RESET = '1;

endpackage

/* sv/byte_set_statistics_top.sv */
// Insert: the first byte of a set goes straight to S_PLACE; any later byte passes S_RD, then S_CMP,
//   where the single compare unit walks the store one read port at a time, shifting each smaller
//   entry down, and then S_PLACE.
// Emit: the beat marked last then passes S_MA, S_MB and S_MC for the median, S_DIV for the
//   bit-serial mean divider, and S_ERD then S_OUT for each result beat; S_OUT waits out a stall.
// Reset: asynchronous, active low; count, sum, maximum, minimum and overflow clear at once.
//   The store needs no clearing pass, since only entries written in the current set are read.
module byte_set_statistics_top
	import bss_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] sample,
	input  logic              last,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] sorted_value,
	output logic [DATA_W-1:0] median,
	output logic [DATA_W-1:0] mean,
	output logic [DATA_W-1:0] maximum,
	output logic [DATA_W-1:0] minimum,
	output logic [CNT_W-1:0]  item_count,
	output logic              overflow,
	output logic              last_out
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam logic [AW-1:0]    ONE_A  = AW'(1);
	localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_ITEMS);
	localparam logic [DCNT_W-1:0] DLAST = DCNT_W'(DIV_W - 1);

	typedef enum logic [3:0] {
		S_IDLE,   // ready for an input beat
		S_RD,     // issue the first read of the insertion walk
		S_CMP,    // compare stored entry with the new byte, shift it down if smaller
		S_PLACE,  // write the new byte into its slot
		S_MA,     // read the upper middle entry
		S_MB,     // read the lower middle entry
		S_MC,     // form the median, load the divider
		S_DIV,    // one quotient bit per cycle
		S_ERD,    // read the next entry to emit
		S_OUT     // result beat on offer
	} state_t;

	state_t state_q;

	// Set statistics
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0] max_q;
	logic [DATA_W-1:0] min_q;
	logic              dropped_q;

	// Insertion walk
	logic [AW-1:0]     pos_q;
	logic [DATA_W-1:0] byte_q;
	logic              last_q;

	// Median and emission
	logic [DATA_W-1:0] mid_a_q;
	logic [DATA_W-1:0] median_q;
	logic [AW-1:0]     k_q;

	// Mean divider
	logic [DIV_W-1:0]     quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [DCNT_W-1:0]    dcnt_q;

	// Value store, one write port and one registered read port
	logic [DATA_W-1:0] store_q [MAX_ITEMS];
	logic [DATA_W-1:0] rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	logic              accept;
	logic              shift_down;
	logic [DIVISOR_W:0] trial;
	logic [DATA_W:0]   mid_sum;
	logic              final_beat;

	assign accept     = in_valid && (state_q == S_IDLE);
	assign shift_down = (state_q == S_CMP) && (rd_data_q < byte_q);
	assign trial      = {rem_q, quo_q[DIV_W-1]};
	assign mid_sum    = {1'b0, mid_a_q} + {1'b0, rd_data_q} + (DATA_W+1)'(1);
	assign final_beat = ({1'b0, k_q} + (AW+1)'(1)) == (AW+1)'(count_q);

	// Read address follows the step of the sequencer
	always_comb begin
		rd_addr = k_q;
		case (state_q)
			S_RD:    rd_addr = pos_q - ONE_A;
			S_CMP:   rd_addr = pos_q - ONE_A - ONE_A;
			S_MA:    rd_addr = AW'((count_q - CNT_W'(1)) >> 1);
			S_MB:    rd_addr = AW'(count_q >> 1);
			default: rd_addr = k_q;
		endcase
	end

	// Write port: shift a smaller entry one slot down, or place the new byte
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = byte_q;
		if (shift_down) begin
			wr_en   = 1'b1;
			wr_data = rd_data_q;
		end else if (state_q == S_PLACE) begin
			wr_en   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_data_q <= store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			sum_q     <= '0;
			max_q     <= '0;
			min_q     <= MIN_RESET;
			dropped_q <= 1'b0;
			pos_q     <= '0;
			byte_q    <= '0;
			last_q    <= 1'b0;
			mid_a_q   <= '0;
			median_q  <= '0;
			k_q       <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
			dcnt_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						byte_q <= sample;
						last_q <= last;
						if (count_q < MAX_C) begin
							// Keep the byte and update the running statistics now
							pos_q   <= count_q[AW-1:0];
							count_q <= count_q + CNT_W'(1);
							sum_q   <= sum_q + SUM_W'(sample);
							if (sample > max_q) max_q <= sample;
							if (sample < min_q) min_q <= sample;
							state_q <= (count_q == '0) ? S_PLACE : S_RD;
						end else begin
							// Store full: drop the byte and flag it
							dropped_q <= 1'b1;
							state_q   <= last ? S_MA : S_IDLE;
						end
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (shift_down) begin
						pos_q <= pos_q - ONE_A;
						if (pos_q == ONE_A) state_q <= S_PLACE;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					state_q <= last_q ? S_MA : S_IDLE;
				end
				S_MA: begin
					state_q <= S_MB;
				end
				S_MB: begin
					mid_a_q <= rd_data_q;
					state_q <= S_MC;
				end
				S_MC: begin
					// For an odd count both reads hit the same entry, so the rounded
					// average is that entry itself
					median_q  <= mid_sum[DATA_W:1];
					quo_q     <= DIV_W'({sum_q, 1'b0}) + DIV_W'(count_q);
					divisor_q <= {count_q, 1'b0};
					rem_q     <= '0;
					dcnt_q    <= '0;
					k_q       <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle
					if (trial >= {1'b0, divisor_q}) begin
						rem_q <= DIVISOR_W'(trial - {1'b0, divisor_q});
						quo_q <= {quo_q[DIV_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[DIVISOR_W-1:0];
						quo_q <= {quo_q[DIV_W-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DLAST) state_q <= S_ERD;
				end
				S_ERD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						if (final_beat) begin
							// Set delivered: return to the empty set
							count_q   <= '0;
							sum_q     <= '0;
							max_q     <= '0;
							min_q     <= MIN_RESET;
							dropped_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							k_q     <= k_q + ONE_A;
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = (state_q == S_OUT);
	assign sorted_value = rd_data_q;
	assign median       = median_q;
	assign mean         = quo_q[DATA_W-1:0];
	assign maximum      = max_q;
	assign minimum      = min_q;
	assign item_count   = count_q;
	assign overflow     = dropped_q;
	assign last_out     = final_beat;

endmodule

/* sv/bss_checker.sv */
module bss_checker
	import bss_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DATA_W-1:0] sorted_value,
	input logic [DATA_W-1:0] median,
	input logic [DATA_W-1:0] mean,
	input logic [DATA_W-1:0] maximum,
	input logic [DATA_W-1:0] minimum,
	input logic [CNT_W-1:0]  item_count,
	input logic              overflow,
	input logic              last_out
);

	// A stalled result beat holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sorted_value) && $stable(median)
			&& $stable(mean) && $stable(item_count) && $stable(last_out))
		else $error("stalled result beat changed");

	// No input is taken while results are on offer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input ready during emission");

	// Every statistic lies within the set's range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> minimum <= sorted_value && sorted_value <= maximum
			&& minimum <= median && median <= maximum
			&& minimum <= mean && mean <= maximum && item_count != '0)
		else $error("statistic outside set range");

	// The final beat of a run ends emission
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_out |=> !out_valid)
		else $error("result beat after last_out");

endmodule

bind byte_set_statistics_top bss_checker u_bss_checker (.*);

/* tb/sv/tb_byte_set_statistics_top.sv */
module tb_byte_set_statistics_top;
	import bss_pkg::*;

	// Store depth of the block under test
	localparam int SET_CAPACITY = 64;
	// Stop the random part once about this many random beats have gone in
	localparam int RANDOM_BEATS = 200;
	// Worst quiet stretch: the longest idle draw before a beat, then a full insertion walk,
	// or the median and divider steps followed by the longest stall on the first result.
	// Allow many times that before giving up.
	localparam int QUIET_LIMIT = 2000;
	// Cycles to keep watching once nothing more is expected
	localparam int SETTLE_CYCLES = 100;

	// How the bytes of a random set are spread
	typedef enum int unsigned {
		SPREAD_FULL,
		SPREAD_NARROW,
		SPREAD_EDGES
	} spread_t;

	// One input beat waiting in the feed
	typedef struct {
		logic [DATA_W-1:0] value;
		logic              last;
		bit                drain_first;
	} in_beat_t;

	// One predicted result beat
	typedef struct {
		logic [DATA_W-1:0] sorted_value;
		logic [DATA_W-1:0] median;
		logic [DATA_W-1:0] mean;
		logic [DATA_W-1:0] maximum;
		logic [DATA_W-1:0] minimum;
		logic [CNT_W-1:0]  item_count;
		logic              overflow;
		logic              last_out;
	} stats_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [DATA_W-1:0] sample = '0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] sorted_value;
	logic [DATA_W-1:0] median;
	logic [DATA_W-1:0] mean;
	logic [DATA_W-1:0] maximum;
	logic [DATA_W-1:0] minimum;
	logic [CNT_W-1:0]  item_count;
	logic              overflow;
	logic              last_out;

	byte_set_statistics_top #(
		.MAX_ITEMS(SET_CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_value(sorted_value),
		.median(median),
		.mean(mean),
		.maximum(maximum),
		.minimum(minimum),
		.item_count(item_count),
		.overflow(overflow),
		.last_out(last_out)
	);

	// Beats still to be sent, and statistics beats still owed by the block
	in_beat_t    feed_beats[$];
	stats_beat_t stats_pending[$];
	stats_beat_t seen_want;
	in_beat_t    next_beat;

	int unsigned beats_queued = 0;
	int unsigned beats_accepted = 0;
	int unsigned quiet_cycles = 0;
	int unsigned in_wait = 0;
	int unsigned in_calm = 0;
	int unsigned out_wait = 0;
	int unsigned out_calm = 0;
	bit          failed = 1'b0;

	// Predictor state: the set as it builds up, largest byte first
	logic [DATA_W-1:0] ranked_bytes[SET_CAPACITY];
	int unsigned       ranked_count = 0;
	int unsigned       byte_total = 0;
	logic [DATA_W-1:0] top_byte = '0;
	logic [DATA_W-1:0] bottom_byte = MIN_RESET;
	bit                bytes_dropped = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Fold one accepted byte into the set; on the closing byte, owe one result beat per
	// kept byte, largest first, and start a fresh set.
	function automatic void absorb_sample(input logic [DATA_W-1:0] v, input logic is_last);
		int unsigned pos;
		int unsigned mid_value;
		int unsigned avg_value;
		stats_beat_t beat;
		if (ranked_count < SET_CAPACITY) begin
			// Shift smaller entries down one place to open a slot for the new byte
			pos = ranked_count;
			while (pos > 0 && ranked_bytes[pos-1] < v) begin
				ranked_bytes[pos] = ranked_bytes[pos-1];
				pos--;
			end
			ranked_bytes[pos] = v;
			ranked_count++;
			byte_total += v;
			if (v > top_byte)
				top_byte = v;
			if (v < bottom_byte)
				bottom_byte = v;
		end else begin
			// Full set: drop the byte, even one marked last
			bytes_dropped = 1'b1;
		end
		if (!is_last)
			return;
		// Median: the middle byte for an odd count; for an even count, average the two middle bytes, rounding half up
		if (ranked_count % 2 == 1)
			mid_value = 32'(ranked_bytes[ranked_count/2]);
		else
			mid_value = (32'(ranked_bytes[(ranked_count-1)/2])
				+ 32'(ranked_bytes[ranked_count/2]) + 1) / 2;
		avg_value = (2 * byte_total + ranked_count) / (2 * ranked_count);
		for (int unsigned k = 0; k < ranked_count; k++) begin
			beat.sorted_value = ranked_bytes[k];
			beat.median       = DATA_W'(mid_value);
			beat.mean         = DATA_W'(avg_value);
			beat.maximum      = top_byte;
			beat.minimum      = bottom_byte;
			beat.item_count   = CNT_W'(ranked_count);
			beat.overflow     = bytes_dropped;
			beat.last_out     = (k + 1 == ranked_count);
			stats_pending.push_back(beat);
		end
		ranked_count  = 0;
		byte_total    = 0;
		top_byte      = '0;
		bottom_byte   = MIN_RESET;
		bytes_dropped = 1'b0;
	endfunction

	// Idle draw shared by both sides: mostly a random idle wait, with calm runs of no idling
	function automatic int unsigned draw_idle(inout int unsigned calm_run);
		if (calm_run > 0) begin
			calm_run--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm_run = $urandom_range(10, 30);
		return $urandom_range(0, 14);
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	task automatic queue_beat(input logic [DATA_W-1:0] v, input logic is_last, input bit drain);
		feed_beats.push_back(in_beat_t'{value: v, last: is_last, drain_first: drain});
		beats_queued++;
	endtask

	// Queue a whole set whose closing beat carries last
	task automatic queue_set(input int unsigned len, input spread_t spread, input bit drain);
		logic [DATA_W-1:0] v;
		for (int unsigned i = 0; i < len; i++) begin
			case (spread)
				SPREAD_NARROW: v = DATA_W'($urandom_range(100, 103));
				SPREAD_EDGES: begin
					if ($urandom_range(0, 1) == 1)
						v = DATA_W'($urandom_range(0, 2));
					else
						v = DATA_W'($urandom_range(253, 255));
				end
				default: v = DATA_W'($urandom);
			endcase
			queue_beat(v, i == len - 1, drain && i == 0);
		end
	endtask

	// Sender: present the head of the feed, hold it while stalled, idle between beats.
	// A beat flagged drain_first waits until every owed result has come back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
			last     <= 1'b0;
			in_wait  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_sample(sample, last);
				beats_accepted++;
				in_wait = draw_idle(in_calm);
			end
			// Hold a stalled beat as it is
			if (!(in_valid && in_stall)) begin
				if (in_wait > 0) begin
					in_wait--;
					in_valid <= 1'b0;
				end else if (feed_beats.size() != 0
						&& !(feed_beats[0].drain_first && stats_pending.size() != 0)) begin
					next_beat = feed_beats.pop_front();
					in_valid <= 1'b1;
					sample   <= next_beat.value;
					last     <= next_beat.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted result against the oldest owed beat, then stall
	// for a drawn number of cycles before taking the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_wait  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (stats_pending.size() == 0) begin
					$error("result beat with none owed: sorted_value %0d", sorted_value);
					failed = 1'b1;
				end else begin
					seen_want = stats_pending.pop_front();
					check_field("sorted_value", seen_want.sorted_value, sorted_value);
					check_field("median", seen_want.median, median);
					check_field("mean", seen_want.mean, mean);
					check_field("maximum", seen_want.maximum, maximum);
					check_field("minimum", seen_want.minimum, minimum);
					check_field("item_count", seen_want.item_count, item_count);
					check_field("overflow", seen_want.overflow, overflow);
					check_field("last_out", seen_want.last_out, last_out);
				end
				out_wait = draw_idle(out_calm);
			end
			if (out_wait > 0) begin
				out_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: give up when neither side has moved a beat for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("byte_set_statistics_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int unsigned random_count;
		int unsigned len;

		// Directed sets first
		// Single byte at each extreme
		queue_beat(8'd0, 1'b1, 1'b0);
		queue_beat(8'd255, 1'b1, 1'b0);
		// Pairs: the median and mean both round half up
		queue_beat(8'd0, 1'b0, 1'b0);
		queue_beat(8'd1, 1'b1, 1'b0);
		queue_beat(8'd255, 1'b0, 1'b0);
		queue_beat(8'd254, 1'b1, 1'b0);
		// All bytes equal
		queue_beat(8'd7, 1'b0, 1'b0);
		queue_beat(8'd7, 1'b0, 1'b0);
		queue_beat(8'd7, 1'b1, 1'b0);
		// Even count with repeated values, arriving out of order
		queue_beat(8'd3, 1'b0, 1'b0);
		queue_beat(8'd200, 1'b0, 1'b0);
		queue_beat(8'd3, 1'b0, 1'b0);
		queue_beat(8'd200, 1'b1, 1'b0);
		// Odd count across the whole range, inserted at the top, the bottom and in between
		queue_beat(8'd10, 1'b0, 1'b0);
		queue_beat(8'd0, 1'b0, 1'b0);
		queue_beat(8'd255, 1'b0, 1'b0);
		queue_beat(8'd128, 1'b0, 1'b0);
		queue_beat(8'd1, 1'b1, 1'b0);

		// Fill the store and drop the closing byte; let the block drain beforehand
		queue_set(SET_CAPACITY + 1, SPREAD_FULL, 1'b1);
		random_count = SET_CAPACITY + 1;
		// Mostly small sets; now and then one near or beyond capacity
		while (random_count < RANDOM_BEATS) begin
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(SET_CAPACITY - 2, SET_CAPACITY + 6);
			else
				len = $urandom_range(1, 12);
			queue_set(len, spread_t'($urandom_range(0, 2)), $urandom_range(0, 5) == 0);
			random_count += len;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every beat to go in and every owed result to come out
		while (beats_accepted != beats_queued)
			@(posedge clk);
		while (stats_pending.size() != 0)
			@(posedge clk);
		// Watch a little longer for stray results
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (!failed)
			$display("byte_set_statistics_top regression: pass");
		else
			$display("byte_set_statistics_top regression: fail");
		$finish;
	end

endmodule
